/* sv/otpc_pkg.sv */
`default_nettype none

package otpc_pkg;

  localparam int unsigned MaxRes = 3;

  typedef logic signed [15:0] coord_t;

  typedef enum logic [1:0] {
    KIND_CONIC = 2'd0,
    KIND_ON    = 2'd1,
    KIND_CUBIC = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CMD_MOVE  = 3'd0,
    CMD_LINE  = 3'd1,
    CMD_QUAD  = 3'd2,
    CMD_CUBIC = 3'd3,
    CMD_CLOSE = 3'd4,
    CMD_ERROR = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_QUAD  = 2'd1,
    ERR_CUBIC = 2'd2
  } err_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   on_curve;
    logic   cubic_control;
    logic   contour_end;
    logic   outline_end;
  } pt_t;

  typedef struct packed {
    cmd_e   cmd;
    err_e   err;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } res_t;

  // results of one point, slot 0 goes out first
  typedef struct packed {
    res_t [MaxRes-1:0] r;
    logic [1:0]        cnt;
  } batch_t;

  function automatic res_t mk_res(cmd_e c, err_e e, coord_t ax, coord_t ay,
                                  coord_t bx, coord_t by, coord_t cx, coord_t cy);
    res_t r;
    r.cmd = c;
    r.err = e;
    r.ax  = ax;
    r.ay  = ay;
    r.bx  = bx;
    r.by  = by;
    r.cx  = cx;
    r.cy  = cy;
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/otpc_decode.sv */
`default_nettype none

module otpc_decode (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire otpc_pkg::pt_t   pt_i,
  input  wire logic            consume_i,
  output otpc_pkg::batch_t     batch_o
);
  import otpc_pkg::*;

  coord_t sx_q, sy_q, px0_q, py0_q, px1_q, py1_q;
  coord_t sx_d, sy_d, px0_d, py0_d, px1_d, py1_d;
  kind_e  rk0_q, rk1_q, rk2_q, rk0_d, rk1_d, rk2_d;
  logic   inc_q, inc_d, drop_q, drop_d;

  kind_e         kind;
  err_e          errk;
  logic          end_o, end_c;
  logic [1:0]    n;
  res_t [MaxRes-1:0] res;
  logic [16:0]   sum_x, sum_y, rnd_x, rnd_y;
  coord_t        mx, my;

  always_comb begin
    sum_x = {px0_q[15], px0_q} + {pt_i.x[15], pt_i.x};
    sum_y = {py0_q[15], py0_q} + {pt_i.y[15], pt_i.y};
    rnd_x = sum_x + {16'd0, sum_x[16]};
    rnd_y = sum_y + {16'd0, sum_y[16]};
    mx    = rnd_x[16:1];
    my    = rnd_y[16:1];
  end

  always_comb begin
    sx_d   = sx_q;
    sy_d   = sy_q;
    px0_d  = px0_q;
    py0_d  = py0_q;
    px1_d  = px1_q;
    py1_d  = py1_q;
    rk0_d  = rk0_q;
    rk1_d  = rk1_q;
    rk2_d  = rk2_q;
    inc_d  = inc_q;
    drop_d = drop_q;
    res    = '0;
    n      = 2'd0;
    errk   = ERR_NONE;
    end_o  = pt_i.outline_end;
    end_c  = pt_i.contour_end | pt_i.outline_end;
    if (pt_i.on_curve) begin
      kind = KIND_ON;
    end else if (pt_i.cubic_control) begin
      kind = KIND_CUBIC;
    end else begin
      kind = KIND_CONIC;
    end

    if (drop_q) begin
      if (end_o) begin
        drop_d = 1'b0;
      end
    end else begin
      if (!inc_q) begin
        res[n] = mk_res(CMD_MOVE, ERR_NONE, pt_i.x, pt_i.y, '0, '0, '0, '0);
        n      = n + 2'd1;
        sx_d   = pt_i.x;
        sy_d   = pt_i.y;
        rk0_d  = kind;
        rk1_d  = KIND_ON;
        rk2_d  = KIND_ON;
        px0_d  = pt_i.x;
        py0_d  = pt_i.y;
        px1_d  = '0;
        py1_d  = '0;
        inc_d  = 1'b1;
      end else begin
        unique case (rk0_q)
          KIND_CONIC: begin
            if (kind == KIND_ON) begin
              res[n] = mk_res(CMD_QUAD, ERR_NONE, px0_q, py0_q, pt_i.x, pt_i.y, '0, '0);
              n      = n + 2'd1;
            end else if (kind == KIND_CONIC) begin
              res[n] = mk_res(CMD_QUAD, ERR_NONE, px0_q, py0_q, mx, my, '0, '0);
              n      = n + 2'd1;
              px0_d  = mx;
              py0_d  = my;
              rk0_d  = KIND_ON;
            end else begin
              errk = ERR_QUAD;
            end
          end
          KIND_CUBIC: begin
            if (kind == KIND_ON) begin
              if (rk1_q == KIND_CUBIC && rk2_q == KIND_ON) begin
                res[n] = mk_res(CMD_CUBIC, ERR_NONE, px1_q, py1_q, px0_q, py0_q,
                                pt_i.x, pt_i.y);
                n      = n + 2'd1;
              end else begin
                errk = ERR_CUBIC;
              end
            end else if (kind == KIND_CONIC || rk1_q != KIND_ON) begin
              errk = ERR_CUBIC;
            end
          end
          default: begin
            if (kind == KIND_ON) begin
              res[n] = mk_res(CMD_LINE, ERR_NONE, pt_i.x, pt_i.y, '0, '0, '0, '0);
              n      = n + 2'd1;
            end
          end
        endcase
        if (errk == ERR_NONE) begin
          rk2_d = rk1_d;
          rk1_d = rk0_d;
          rk0_d = kind;
          px1_d = px0_d;
          py1_d = py0_d;
          px0_d = pt_i.x;
          py0_d = pt_i.y;
        end
      end

      if (errk == ERR_NONE && end_c) begin
        unique case (rk0_d)
          KIND_CONIC: begin
            res[n] = mk_res(CMD_QUAD, ERR_NONE, px0_d, py0_d, sx_d, sy_d, '0, '0);
            n      = n + 2'd1;
          end
          KIND_CUBIC: begin
            if (rk1_d == KIND_CUBIC && rk2_d == KIND_ON) begin
              res[n] = mk_res(CMD_CUBIC, ERR_NONE, px1_d, py1_d, px0_d, py0_d,
                              sx_d, sy_d);
              n      = n + 2'd1;
            end else begin
              errk = ERR_CUBIC;
            end
          end
          default: begin
            res[n] = mk_res(CMD_LINE, ERR_NONE, sx_d, sy_d, '0, '0, '0, '0);
            n      = n + 2'd1;
          end
        endcase
        if (errk == ERR_NONE) begin
          res[n] = mk_res(CMD_CLOSE, ERR_NONE, '0, '0, '0, '0, '0, '0);
          n      = n + 2'd1;
        end
        inc_d = 1'b0;
      end

      if (errk != ERR_NONE) begin
        res[n] = mk_res(CMD_ERROR, errk, '0, '0, '0, '0, '0, '0);
        n      = n + 2'd1;
        inc_d  = 1'b0;
        drop_d = ~end_o;
      end
    end

    batch_o.r   = res;
    batch_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= '0;
      sy_q   <= '0;
      px0_q  <= '0;
      py0_q  <= '0;
      px1_q  <= '0;
      py1_q  <= '0;
      rk0_q  <= KIND_ON;
      rk1_q  <= KIND_ON;
      rk2_q  <= KIND_ON;
      inc_q  <= 1'b0;
      drop_q <= 1'b0;
    end else if (consume_i) begin
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      px0_q  <= px0_d;
      py0_q  <= py0_d;
      px1_q  <= px1_d;
      py1_q  <= py1_d;
      rk0_q  <= rk0_d;
      rk1_q  <= rk1_d;
      rk2_q  <= rk2_d;
      inc_q  <= inc_d;
      drop_q <= drop_d;
    end
  end

endmodule

`default_nettype wire

/* sv/otpc_outbuf.sv */
`default_nettype none

module otpc_outbuf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire otpc_pkg::batch_t batch_i,
  input  wire logic             consume_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output otpc_pkg::res_t        head_o,
  output logic                  last_o
);
  import otpc_pkg::*;

  res_t [MaxRes-1:0] slots_q, slots_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              take, push;

  assign take    = (cnt_q != 2'd0) && !out_stall_i;
  assign space_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take);
  assign push    = consume_i && (batch_i.cnt != 2'd0);

  always_comb begin
    slots_d = slots_q;
    cnt_d   = cnt_q;
    if (push) begin
      slots_d = batch_i.r;
      cnt_d   = batch_i.cnt;
    end else if (take) begin
      slots_d[0] = slots_q[1];
      slots_d[1] = slots_q[2];
      slots_d[2] = '0;
      cnt_d      = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = slots_q[0];
  assign last_o      = (cnt_q == 2'd1);

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && take)))
    else $error("batch loaded over undelivered results");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && take && !push) |=> (cnt_q == 2'd1))
    else $error("result count did not step down");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0 && !take && !push) |=> $stable(slots_q) && $stable(cnt_q))
    else $error("waiting results changed");

endmodule

`default_nettype wire

/* sv/outline_to_path_commands.sv */
// Turns a stream of glyph outline points into path commands (move, line, quad,
// cubic, close, error), one command per output transaction, run_last_o marking
// the final command caused by a point. A point is registered on input, decoded
// combinationally against the contour state once there is room, and its
// commands (up to three) are loaded into a result register that drains one
// command per cycle unless the output stalls; the first command is presented
// on the output from that register. The single result port sets the pace: a
// point's commands load as the last waiting command is taken, and the input
// stalls while a registered point waits for room, so output stalls hold the
// input. After an error the remaining points of the outline are taken without
// results.
`default_nettype none

module outline_to_path_commands (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire otpc_pkg::coord_t     point_x_i,
  input  wire otpc_pkg::coord_t     point_y_i,
  input  wire logic                 on_curve_i,
  input  wire logic                 cubic_control_i,
  input  wire logic                 contour_end_i,
  input  wire logic                 outline_end_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [2:0]                command_o,
  output logic [1:0]                error_kind_o,
  output otpc_pkg::coord_t          ax_o,
  output otpc_pkg::coord_t          ay_o,
  output otpc_pkg::coord_t          bx_o,
  output otpc_pkg::coord_t          by_o,
  output otpc_pkg::coord_t          cx_o,
  output otpc_pkg::coord_t          cy_o,
  output logic                      run_last_o
);
  import otpc_pkg::*;

  pt_t    pt_q;
  logic   vld_q;
  logic   accept, consume, space;
  batch_t batch;
  res_t   head;

  assign consume    = vld_q && space;
  assign in_stall_o = vld_q && !space;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (consume) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q.x             <= point_x_i;
      pt_q.y             <= point_y_i;
      pt_q.on_curve      <= on_curve_i;
      pt_q.cubic_control <= cubic_control_i;
      pt_q.contour_end   <= contour_end_i;
      pt_q.outline_end   <= outline_end_i;
    end
  end

  otpc_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pt_i      (pt_q),
    .consume_i (consume),
    .batch_o   (batch)
  );

  otpc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .batch_i     (batch),
    .consume_i   (consume),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head),
    .last_o      (run_last_o)
  );

  assign command_o    = head.cmd;
  assign error_kind_o = head.err;
  assign ax_o         = head.ax;
  assign ay_o         = head.ay;
  assign bx_o         = head.bx;
  assign by_o         = head.by;
  assign cx_o         = head.cx;
  assign cy_o         = head.cy;

endmodule

`default_nettype wire

/* tb/sv/path_cmd_checker.sv */
`timescale 1ns / 100ps

module path_cmd_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  otpc_pkg::coord_t point_x_i,
  input  otpc_pkg::coord_t point_y_i,
  input  logic             on_curve_i,
  input  logic             cubic_control_i,
  input  logic             contour_end_i,
  input  logic             outline_end_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [2:0]       command_i,
  input  logic [1:0]       error_kind_i,
  input  otpc_pkg::coord_t ax_i,
  input  otpc_pkg::coord_t ay_i,
  input  otpc_pkg::coord_t bx_i,
  input  otpc_pkg::coord_t by_i,
  input  otpc_pkg::coord_t cx_i,
  input  otpc_pkg::coord_t cy_i,
  input  logic             run_last_i,
  output int               mismatches_o,
  output int               pending_o
);
  import otpc_pkg::*;

  typedef struct {
    cmd_e   cmd;
    err_e   err;
    coord_t ax, ay, bx, by, cx, cy;
    logic   last;
  } path_cmd_t;

  path_cmd_t cmd_q[$];
  path_cmd_t point_cmds[$];
  coord_t    start_x, start_y;
  coord_t    hist_x[2], hist_y[2];
  kind_e     hist_k[3];
  logic      contour_open;
  logic      skipping;
  int        seen;

  task automatic report_mismatch(string msg);
    if (mismatches_o < 40) begin
      $display("%0t ERROR: %s", $realtime, msg);
    end
    mismatches_o++;
  endtask

  task automatic add_cmd(cmd_e c, err_e e, coord_t ax, coord_t ay, coord_t bx, coord_t by,
                         coord_t cx, coord_t cy);
    path_cmd_t pc;
    pc = '{c, e, ax, ay, bx, by, cx, cy, 1'b0};
    point_cmds.push_back(pc);
  endtask

  // Commands caused by the point on the input ports, appended to cmd_q.
  task automatic decode_point();
    err_e   err;
    logic   end_o, end_c;
    kind_e  k;
    coord_t x, y;
    int     mx, my;
    err   = ERR_NONE;
    end_o = outline_end_i;
    end_c = contour_end_i | outline_end_i;
    x     = point_x_i;
    y     = point_y_i;
    point_cmds.delete();
    if (skipping) begin
      if (end_o) skipping = 1'b0;
      return;
    end
    if (on_curve_i) k = KIND_ON;
    else if (cubic_control_i) k = KIND_CUBIC;
    else k = KIND_CONIC;

    if (!contour_open) begin
      add_cmd(CMD_MOVE, ERR_NONE, x, y, 0, 0, 0, 0);
      start_x      = x;
      start_y      = y;
      hist_k       = '{k, KIND_ON, KIND_ON};
      hist_x[0]    = x;
      hist_y[0]    = y;
      hist_x[1]    = '0;
      hist_y[1]    = '0;
      contour_open = 1'b1;
    end else begin
      case (hist_k[0])
        KIND_CONIC: begin
          if (k == KIND_ON) begin
            add_cmd(CMD_QUAD, ERR_NONE, hist_x[0], hist_y[0], x, y, 0, 0);
          end else if (k == KIND_CONIC) begin
            mx = (int'(hist_x[0]) + int'(x)) / 2;
            my = (int'(hist_y[0]) + int'(y)) / 2;
            add_cmd(CMD_QUAD, ERR_NONE, hist_x[0], hist_y[0], coord_t'(mx), coord_t'(my), 0, 0);
            hist_x[0] = coord_t'(mx);
            hist_y[0] = coord_t'(my);
            hist_k[0] = KIND_ON;
          end else begin
            err = ERR_QUAD;
          end
        end
        KIND_CUBIC: begin
          if (k == KIND_ON) begin
            if (hist_k[1] == KIND_CUBIC && hist_k[2] == KIND_ON)
              add_cmd(CMD_CUBIC, ERR_NONE, hist_x[1], hist_y[1], hist_x[0], hist_y[0], x, y);
            else
              err = ERR_CUBIC;
          end else if (k == KIND_CONIC || hist_k[1] != KIND_ON) begin
            err = ERR_CUBIC;
          end
        end
        default: begin
          if (k == KIND_ON) add_cmd(CMD_LINE, ERR_NONE, x, y, 0, 0, 0, 0);
        end
      endcase
      if (err == ERR_NONE) begin
        hist_k[2] = hist_k[1];
        hist_k[1] = hist_k[0];
        hist_k[0] = k;
        hist_x[1] = hist_x[0];
        hist_y[1] = hist_y[0];
        hist_x[0] = x;
        hist_y[0] = y;
      end
    end

    // closing segment back to the contour start
    if (err == ERR_NONE && end_c) begin
      case (hist_k[0])
        KIND_CONIC: add_cmd(CMD_QUAD, ERR_NONE, hist_x[0], hist_y[0], start_x, start_y, 0, 0);
        KIND_CUBIC: begin
          if (hist_k[1] == KIND_CUBIC && hist_k[2] == KIND_ON)
            add_cmd(CMD_CUBIC, ERR_NONE, hist_x[1], hist_y[1], hist_x[0], hist_y[0],
                    start_x, start_y);
          else
            err = ERR_CUBIC;
        end
        default: add_cmd(CMD_LINE, ERR_NONE, start_x, start_y, 0, 0, 0, 0);
      endcase
      if (err == ERR_NONE) add_cmd(CMD_CLOSE, ERR_NONE, 0, 0, 0, 0, 0, 0);
      contour_open = 1'b0;
    end

    if (err != ERR_NONE) begin
      add_cmd(CMD_ERROR, err, 0, 0, 0, 0, 0, 0);
      contour_open = 1'b0;
      skipping     = !end_o;
    end

    if (point_cmds.size() > 0) point_cmds[$].last = 1'b1;
    foreach (point_cmds[i]) cmd_q.push_back(point_cmds[i]);
  endtask

  task automatic check_result();
    path_cmd_t want;
    if (cmd_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction: cmd %0d err %0d last %0b",
                                command_i, error_kind_i, run_last_i));
      return;
    end
    want = cmd_q.pop_front();
    seen++;
    if (command_i !== want.cmd || error_kind_i !== want.err || ax_i !== want.ax ||
        ay_i !== want.ay || bx_i !== want.bx || by_i !== want.by || cx_i !== want.cx ||
        cy_i !== want.cy || run_last_i !== want.last) begin
      report_mismatch($sformatf({"transaction %0d: got cmd %0d err %0d a(%0d,%0d) b(%0d,%0d)",
                                 " c(%0d,%0d) last %0b; want cmd %0d err %0d a(%0d,%0d)",
                                 " b(%0d,%0d) c(%0d,%0d) last %0b"},
                                seen, command_i, error_kind_i, ax_i, ay_i, bx_i, by_i,
                                cx_i, cy_i, run_last_i, want.cmd, want.err, want.ax, want.ay,
                                want.bx, want.by, want.cx, want.cy, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q.delete();
      start_x      = '0;
      start_y      = '0;
      hist_x       = '{default: '0};
      hist_y       = '{default: '0};
      hist_k       = '{KIND_ON, KIND_ON, KIND_ON};
      contour_open = 1'b0;
      skipping     = 1'b0;
      seen         = 0;
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if ($isunknown(out_valid_i) || $isunknown(in_stall_i))
        report_mismatch("unknown value on out_valid or in_stall");
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) decode_point();
      pending_o = cmd_q.size();
    end
  end

endmodule

/* tb/sv/tb_outline_to_path_commands.sv */
`timescale 1ns / 100ps

module tb_outline_to_path_commands;
  import otpc_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int PhaseItems = 45;
  localparam int HoldCycles = 50;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  coord_t     pt_x = '0;
  coord_t     pt_y = '0;
  logic       pt_on = 1'b0;
  logic       pt_cubic = 1'b0;
  logic       pt_cend = 1'b0;
  logic       pt_oend = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] command;
  logic [1:0] error_kind;
  coord_t     ax, ay, bx, by, cx, cy;
  logic       run_last;

  int   mismatches;
  int   pending;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  pt_t  pt_q[$];

  always #5 clk_i = ~clk_i;

  outline_to_path_commands u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .point_x_i      (pt_x),
    .point_y_i      (pt_y),
    .on_curve_i     (pt_on),
    .cubic_control_i(pt_cubic),
    .contour_end_i  (pt_cend),
    .outline_end_i  (pt_oend),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .command_o      (command),
    .error_kind_o   (error_kind),
    .ax_o           (ax),
    .ay_o           (ay),
    .bx_o           (bx),
    .by_o           (by),
    .cx_o           (cx),
    .cy_o           (cy),
    .run_last_o     (run_last)
  );

  path_cmd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .point_x_i      (pt_x),
    .point_y_i      (pt_y),
    .on_curve_i     (pt_on),
    .cubic_control_i(pt_cubic),
    .contour_end_i  (pt_cend),
    .outline_end_i  (pt_oend),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .command_i      (command),
    .error_kind_i   (error_kind),
    .ax_i           (ax),
    .ay_i           (ay),
    .bx_i           (bx),
    .by_i           (by),
    .cx_i           (cx),
    .cy_i           (cy),
    .run_last_i     (run_last),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // result side: random stall, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_point(coord_t x, coord_t y, logic on_pt, logic cubic, logic c_end,
                            logic o_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    pt_x     <= x;
    pt_y     <= y;
    pt_on    <= on_pt;
    pt_cubic <= cubic;
    pt_cend  <= c_end;
    pt_oend  <= o_end;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic build_contour(logic last_one);
    kind_e kinds[$];
    int    n;
    pt_t   p;
    case ($urandom_range(9))
      0: kinds.push_back(KIND_CONIC);
      1: begin
        kinds.push_back(KIND_CUBIC);
        kinds.push_back(KIND_CUBIC);
        kinds.push_back(KIND_ON);
      end
      default: kinds.push_back(KIND_ON);
    endcase
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(3))
        0: kinds.push_back(KIND_ON);
        1: begin
          kinds.push_back(KIND_CONIC);
          kinds.push_back(KIND_ON);
        end
        2: begin
          repeat ($urandom_range(2, 3)) kinds.push_back(KIND_CONIC);
          kinds.push_back(KIND_ON);
        end
        default: begin
          kinds.push_back(KIND_CUBIC);
          kinds.push_back(KIND_CUBIC);
          kinds.push_back(KIND_ON);
        end
      endcase
    end
    // drop the last point, often leaving the contour on an off point so the close does the work
    if ($urandom_range(2) == 0) void'(kinds.pop_back());
    // broken sequence
    if ($urandom_range(6) == 0) kinds[$urandom_range(kinds.size() - 1)] = kind_e'($urandom_range(2));
    n = kinds.size();
    foreach (kinds[i]) begin
      p.x             = rand_coord();
      p.y             = rand_coord();
      p.on_curve      = (kinds[i] == KIND_ON);
      p.cubic_control = p.on_curve ? 1'($urandom_range(1)) : (kinds[i] == KIND_CUBIC);
      if (i == n - 1) begin
        p.contour_end = !(last_one && $urandom_range(1) == 1);
        p.outline_end = last_one;
      end else begin
        p.contour_end = ($urandom_range(49) == 0);
        p.outline_end = 1'b0;
      end
      pt_q.push_back(p);
    end
  endtask

  task automatic build_outline();
    int  loop_cnt;
    pt_t p;
    if ($urandom_range(7) == 0) begin
      // noise: random kinds and marks
      repeat ($urandom_range(3, 6)) begin
        p.x                          = rand_coord();
        p.y                          = rand_coord();
        {p.on_curve, p.cubic_control} = 2'($urandom);
        p.contour_end                = ($urandom_range(3) == 0);
        p.outline_end                = 1'b0;
        pt_q.push_back(p);
      end
      pt_q[$].outline_end = 1'b1;
    end else begin
      loop_cnt = $urandom_range(1, 3);
      for (int c = 0; c < loop_cnt; c++) build_contour(c == loop_cnt - 1);
    end
  endtask

  initial begin
    int  sent;
    pt_t p;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes, truncating midpoint, cubic, close from conic
    send_point(-16'sd32768, 16'sd32767, 1'b1, 1'b0, 1'b0, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1'b1, 1'b1, 1'b0, 1'b0);
    send_point(-16'sd3, 16'sd5, 1'b0, 1'b0, 1'b0, 1'b0);
    send_point(16'sd4, -16'sd8, 1'b0, 1'b0, 1'b0, 1'b0);
    send_point(-16'sd32768, -16'sd32768, 1'b1, 1'b0, 1'b0, 1'b0);
    send_point(16'sd7, 16'sd7, 1'b0, 1'b1, 1'b0, 1'b0);
    send_point(16'sd9, 16'sd9, 1'b0, 1'b1, 1'b0, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b1, 1'b0, 1'b0, 1'b0);
    send_point(16'sd1, -16'sd1, 1'b0, 1'b0, 1'b1, 1'b0);
    // contour opened by an off point, closed by a cubic
    send_point(16'sd5, 16'sd5, 1'b0, 1'b0, 1'b0, 1'b0);
    send_point(16'sd6, 16'sd6, 1'b1, 1'b1, 1'b0, 1'b0);
    send_point(16'sd8, 16'sd8, 1'b0, 1'b1, 1'b0, 1'b0);
    send_point(16'sd9, -16'sd9, 1'b0, 1'b1, 1'b1, 1'b0);
    // single point, outline end without contour end
    send_point(16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b1);
    // conic then cubic, rest of outline dropped
    send_point(16'sd1, 16'sd1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0, 1'b0, 1'b0, 1'b0);
    send_point(16'sd3, 16'sd3, 1'b0, 1'b1, 1'b0, 1'b0);
    send_point(16'sd4, 16'sd4, 1'b1, 1'b0, 1'b1, 1'b1);
    // cubic then conic, error on the outline end point itself
    send_point(16'sd1, 16'sd1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0, 1'b1, 1'b0, 1'b0);
    send_point(16'sd3, 16'sd3, 1'b0, 1'b0, 1'b0, 1'b1);
    // three cubic controls in a row
    send_point(16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_point(16'sd1, 16'sd2, 1'b0, 1'b1, 1'b0, 1'b0);
    send_point(16'sd3, 16'sd4, 1'b0, 1'b1, 1'b0, 1'b0);
    send_point(16'sd5, 16'sd6, 1'b0, 1'b1, 1'b0, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
          hold_req     <= ~hold_req;
        end
        1: begin
          send_idle_pct = 88;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 88;
        end
        default: begin
          send_idle_pct = 37;
          stall_pct    <= 37;
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        build_outline();
        while (pt_q.size() > 0) begin
          p = pt_q.pop_front();
          send_point(p.x, p.y, p.on_curve, p.cubic_control, p.contour_end, p.outline_end);
          sent++;
        end
      end
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
